>>> hw/rtl/fhcc_pkg.sv
package fhcc_pkg;

    localparam int HEADER_BYTES  = 24;
    localparam int HDR_IDX_W     = $clog2(HEADER_BYTES);
    localparam int COUNT_W       = 17;
    localparam int CRC_COVER_END = 20;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 3;

    localparam logic [31:0]        CRC_POLY  = 32'hedb88320;
    localparam logic [31:0]        CRC_INIT  = 32'hffffffff;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_TRUNCATED = 4'd1;
    localparam logic [3:0] ST_MAGIC     = 4'd2;
    localparam logic [3:0] ST_VERSION   = 4'd3;
    localparam logic [3:0] ST_CLASS     = 4'd4;
    localparam logic [3:0] ST_FLAGS     = 4'd5;
    localparam logic [3:0] ST_RESERVED  = 4'd6;
    localparam logic [3:0] ST_OVERSIZED = 4'd7;
    localparam logic [3:0] ST_CRC       = 4'd8;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_MAGIC   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SUPP_MAJOR    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_MINOR     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FLAGS_MASK    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_CLASS     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD   = 3'd5;

    typedef logic [HEADER_BYTES-1:0][7:0] t_header;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [31:0]        crc;
        t_header            header;
    } t_frame_view;

    typedef struct packed {
        logic [15:0] frame_magic;
        logic [7:0]  major_ver;
        logic [7:0]  max_minor;
        logic [7:0]  allowed_flags_mask;
        logic [7:0]  max_msg_class;
        logic [15:0] max_payload;
    } t_config;

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  major;
        logic [7:0]  minor;
        logic [7:0]  msg_class;
        logic [7:0]  frame_flags;
        logic [15:0] msg_type;
        logic [31:0] req_id;
        logic [31:0] sequence_number;
        logic [15:0] payload_length;
    } t_result;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

>>> hw/rtl/fhcc_in_if.sv
interface fhcc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> hw/rtl/fhcc_out_if.sv
interface fhcc_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [7:0]  major;
    logic [7:0]  minor;
    logic [7:0]  msg_class;
    logic [7:0]  frame_flags;
    logic [15:0] msg_type;
    logic [31:0] req_id;
    logic [31:0] sequence_number;
    logic [15:0] payload_length;

    modport source (
        output valid, output status, output major, output minor, output msg_class,
        output frame_flags, output msg_type, output req_id,
        output sequence_number, output payload_length, input ready
    );
    modport sink (
        input valid, input status, input major, input minor, input msg_class,
        input frame_flags, input msg_type, input req_id,
        input sequence_number, input payload_length, output ready
    );
endinterface

>>> hw/rtl/frame_header_crc_checker_top.sv
// Frame header and CRC checker. Frames arrive one byte per beat on i_in, with last_byte set on
// the final beat; each final beat yields exactly one result beat on o_out, and other beats yield
// none. A beat is taken every cycle unless a final byte waits on an untaken result: each byte
// passes an input register, one pass of byte count, header store and an unrolled eight-step
// CRC-32 update, and, on the final byte, the header checks into the result register, which
// offers the result. Only a final byte waits while an earlier result has not been taken. The
// status code follows a fixed priority: truncated header, bad magic, version, class, flags,
// reserved, oversized payload, length short or long, CRC. Fields are zero unless status is ok.
// The user writes registers through i_cfg_* only with no frame in flight; the block won't check.
module frame_header_crc_checker_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [fhcc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [fhcc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    fhcc_in_if.sink                             i_in,
    fhcc_out_if.source                          o_out
);

    fhcc_pkg::t_config     r_cfg;
    fhcc_pkg::t_frame_view view;
    fhcc_pkg::t_result     check_res;
    fhcc_pkg::t_result     r_res;

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_out_valid;
    logic       out_free;
    logic       s1_adv;
    logic       in_ready;

    assign out_free = !r_out_valid || o_out.ready;
    assign s1_adv   = r_in_valid && (!r_last || out_free);
    assign in_ready = !r_in_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_magic        <= 16'd0;
            r_cfg.major_ver          <= 8'd1;
            r_cfg.max_minor          <= 8'd0;
            r_cfg.allowed_flags_mask <= 8'd0;
            r_cfg.max_msg_class      <= 8'd0;
            r_cfg.max_payload        <= 16'hffff;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                fhcc_pkg::REG_FRAME_MAGIC: r_cfg.frame_magic        <= i_cfg_data;
                fhcc_pkg::REG_SUPP_MAJOR:  r_cfg.major_ver          <= i_cfg_data[7:0];
                fhcc_pkg::REG_MAX_MINOR:   r_cfg.max_minor          <= i_cfg_data[7:0];
                fhcc_pkg::REG_FLAGS_MASK:  r_cfg.allowed_flags_mask <= i_cfg_data[7:0];
                fhcc_pkg::REG_MAX_CLASS:   r_cfg.max_msg_class      <= i_cfg_data[7:0];
                fhcc_pkg::REG_MAX_PAYLOAD: r_cfg.max_payload        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_byte <= i_in.data_byte;
            r_last <= i_in.last_byte;
        end
    end

    fhcc_frame_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (s1_adv),
        .i_byte  (r_byte),
        .i_last  (r_last),
        .o_view  (view)
    );

    fhcc_status_check u_check (
        .i_view   (view),
        .i_cfg    (r_cfg),
        .o_result (check_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_last) begin
            r_res <= check_res;
        end
    end

    assign i_in.ready            = in_ready;
    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_res.status;
    assign o_out.major           = r_res.major;
    assign o_out.minor           = r_res.minor;
    assign o_out.msg_class       = r_res.msg_class;
    assign o_out.frame_flags     = r_res.frame_flags;
    assign o_out.msg_type        = r_res.msg_type;
    assign o_out.req_id          = r_res.req_id;
    assign o_out.sequence_number = r_res.sequence_number;
    assign o_out.payload_length  = r_res.payload_length;

    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.status != fhcc_pkg::ST_OK |->
            r_res.major == 8'd0 && r_res.req_id == 32'd0 &&
            r_res.sequence_number == 32'd0 && r_res.payload_length == 16'd0)
        else $error("header fields nonzero on error status");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_res.status <= fhcc_pkg::ST_CRC)
        else $error("status code out of range");

    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_last && r_out_valid && !o_out.ready |=> r_in_valid && r_last)
        else $error("last beat dropped while result pending");

endmodule

>>> hw/rtl/fhcc_frame_state.sv
module fhcc_frame_state (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output fhcc_pkg::t_frame_view o_view
);

    logic [fhcc_pkg::COUNT_W-1:0] r_count, n_count;
    logic [31:0]                  r_crc, n_crc;
    fhcc_pkg::t_header            r_header, n_header;
    logic                         crc_cover;

    always_comb begin
        n_header = r_header;
        if (r_count < fhcc_pkg::COUNT_W'(fhcc_pkg::HEADER_BYTES)) begin
            n_header[r_count[fhcc_pkg::HDR_IDX_W-1:0]] = i_byte;
        end
        crc_cover = (r_count < fhcc_pkg::COUNT_W'(fhcc_pkg::CRC_COVER_END)) ||
                    (r_count >= fhcc_pkg::COUNT_W'(fhcc_pkg::HEADER_BYTES));
        n_crc   = crc_cover ? fhcc_pkg::crc_byte(r_crc, i_byte) : r_crc;
        n_count = (r_count == fhcc_pkg::COUNT_MAX) ? r_count : r_count + 1'b1;
    end

    assign o_view = '{count: n_count, crc: n_crc, header: n_header};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= fhcc_pkg::CRC_INIT;
        end else if (i_adv) begin
            if (i_last) begin
                r_count <= '0;
                r_crc   <= fhcc_pkg::CRC_INIT;
            end else begin
                r_count <= n_count;
                r_crc   <= n_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && !i_last) begin
            r_header <= n_header;
        end
    end

    // The end of a frame returns the running state to its start values.
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_last |=> r_count == '0 && r_crc == fhcc_pkg::CRC_INIT)
        else $error("frame state not cleared after last beat");

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && !i_last && r_count == fhcc_pkg::COUNT_MAX |=> r_count == fhcc_pkg::COUNT_MAX)
        else $error("byte count wrapped");

endmodule

>>> hw/rtl/fhcc_status_check.sv
module fhcc_status_check (
    input  fhcc_pkg::t_frame_view i_view,
    input  fhcc_pkg::t_config     i_cfg,
    output fhcc_pkg::t_result     o_result
);

    fhcc_pkg::t_header            h;
    logic [15:0]                  plen;
    logic [fhcc_pkg::COUNT_W-1:0] expect_size;
    logic [3:0]                   status;

    assign h           = i_view.header;
    assign plen        = {h[17], h[16]};
    assign expect_size = fhcc_pkg::COUNT_W'(fhcc_pkg::HEADER_BYTES) + {1'b0, plen};

    always_comb begin
        if (i_view.count < fhcc_pkg::COUNT_W'(fhcc_pkg::HEADER_BYTES)) begin
            status = fhcc_pkg::ST_TRUNCATED;
        end else if ({h[1], h[0]} != i_cfg.frame_magic) begin
            status = fhcc_pkg::ST_MAGIC;
        end else if (h[2] != i_cfg.major_ver || h[3] > i_cfg.max_minor) begin
            status = fhcc_pkg::ST_VERSION;
        end else if (h[4] > i_cfg.max_msg_class) begin
            status = fhcc_pkg::ST_CLASS;
        end else if ((h[5] & ~i_cfg.allowed_flags_mask) != 8'd0) begin
            status = fhcc_pkg::ST_FLAGS;
        end else if ({h[19], h[18]} != 16'd0) begin
            status = fhcc_pkg::ST_RESERVED;
        end else if (plen > i_cfg.max_payload) begin
            status = fhcc_pkg::ST_OVERSIZED;
        end else if (i_view.count < expect_size) begin
            status = fhcc_pkg::ST_TRUNCATED;
        end else if (i_view.count > expect_size) begin
            status = fhcc_pkg::ST_OVERSIZED;
        end else if ((i_view.crc ^ fhcc_pkg::CRC_INIT) != {h[23], h[22], h[21], h[20]}) begin
            status = fhcc_pkg::ST_CRC;
        end else begin
            status = fhcc_pkg::ST_OK;
        end
    end

    always_comb begin
        o_result        = '0;
        o_result.status = status;
        if (status == fhcc_pkg::ST_OK) begin
            o_result.major           = h[2];
            o_result.minor           = h[3];
            o_result.msg_class       = h[4];
            o_result.frame_flags     = h[5];
            o_result.msg_type        = {h[7], h[6]};
            o_result.req_id          = {h[11], h[10], h[9], h[8]};
            o_result.sequence_number = {h[15], h[14], h[13], h[12]};
            o_result.payload_length  = plen;
        end
    end

endmodule
